// File: sv/cmfuv_pkg.sv
`timescale 1ns / 1ps
package cmfuv_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int UV_BITS_DEF    = 16;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_PY = 3'd1,
    FACE_PZ = 3'd2,
    FACE_NX = 3'd3,
    FACE_NY = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

endpackage

// File: sv/cmfuv_if.sv
`timescale 1ns / 1ps
interface cmfuv_dir_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmfuv_uv_if #(parameter int UV_BITS = 16);
  logic               valid;
  logic               ready;
  logic [2:0]         face;
  logic [UV_BITS-1:0] face_u;
  logic [UV_BITS-1:0] face_v;
  logic [UV_BITS-1:0] atlas_u;
  logic [UV_BITS-1:0] atlas_v;
  logic               no_dominant_axis;
  modport source (output valid, face, face_u, face_v, atlas_u, atlas_v, no_dominant_axis,
                  input ready);
  modport sink   (input valid, face, face_u, face_v, atlas_u, atlas_v, no_dominant_axis,
                  output ready);
endinterface

// File: sv/cube_map_face_uv_top.sv
`timescale 1ns / 1ps
// throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so the one-bit-per-stage divider sets the depth
// reset: synchronous active-high rst clears all stage valid bits; data regs are not reset
module cube_map_face_uv_top
  import cmfuv_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int UV_BITS    = UV_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  cmfuv_dir_if.sink           dir_in,
  cmfuv_uv_if.source          uv_out
);

  localparam int C  = COORD_BITS;
  localparam int D  = UV_BITS - 1;           // divider stages, one quotient bit each
  localparam int S  = UV_BITS + 3;           // reciprocal shift for divide by 3
  localparam longint MUL = ((64'd1 << S) + 64'd2) / 64'd3;
  localparam logic [S-1:0] MULV = MUL[S-1:0];
  localparam longint K1L = (64'd1 << UV_BITS) / 64'd3;
  localparam longint R0L = (64'd1 << UV_BITS) % 64'd3;
  localparam logic [UV_BITS-1:0] K1 = K1L[UV_BITS-1:0];
  localparam logic [UV_BITS-1:0] K2 = K1L[UV_BITS-2:0] << 1;
  localparam logic [2:0]         R1 = R0L[2:0];
  localparam logic [2:0]         R2 = R0L[1:0] << 1;
  localparam logic [UV_BITS-1:0] HALF = {1'b1, {(UV_BITS-1){1'b0}}};

  // whole pipe moves as one; a stalled output freezes every stage
  logic adv;
  assign adv = !uv_out.valid || uv_out.ready;
  assign dir_in.ready = adv;

  // stage 1: magnitudes and signs
  logic         v1;
  logic [C-1:0] ax, ay, az;
  logic         sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= dir_in.valid;
    end
    if (adv) begin
      sx <= dir_in.dir_x[C-1];
      sy <= dir_in.dir_y[C-1];
      sz <= dir_in.dir_z[C-1];
      ax <= dir_in.dir_x[C-1] ? C'(-dir_in.dir_x) : C'(dir_in.dir_x);
      ay <= dir_in.dir_y[C-1] ? C'(-dir_in.dir_y) : C'(dir_in.dir_y);
      az <= dir_in.dir_z[C-1] ? C'(-dir_in.dir_z) : C'(dir_in.dir_z);
    end
  end

  // stage 2: face pick by priority, major and signed minors
  logic         dom [0:5];
  logic         px, py, pz;
  face_t        f2;
  logic         nd2, nu2, nv2;
  logic [C-1:0] mj2, mu2, mv2;

  always_comb begin
    px = !sx && (ax != '0);
    py = !sy && (ay != '0);
    pz = !sz && (az != '0);
    dom[0] = px && (ay < ax) && (az < ax);
    dom[1] = py && (ax < ay) && (az < ay);
    dom[2] = pz && (ax < az) && (ay < az);
    dom[3] = sx && (ay < ax) && (az < ax);
    dom[4] = sy && (ax < ay) && (az < ay);
    dom[5] = sz && (ax < az) && (ay < az);
    nd2 = 1'b0;
    f2  = FACE_PX;
    mj2 = C'(1);
    mu2 = '0;
    mv2 = '0;
    nu2 = 1'b0;
    nv2 = 1'b0;
    if (dom[0]) begin
      f2 = FACE_PX; mj2 = ax; mu2 = az; nu2 = !sz; mv2 = ay; nv2 = !sy;
    end else if (dom[1]) begin
      f2 = FACE_PY; mj2 = ay; mu2 = ax; nu2 = sx;  mv2 = az; nv2 = sz;
    end else if (dom[2]) begin
      f2 = FACE_PZ; mj2 = az; mu2 = ax; nu2 = sx;  mv2 = ay; nv2 = !sy;
    end else if (dom[3]) begin
      f2 = FACE_NX; mj2 = ax; mu2 = az; nu2 = sz;  mv2 = ay; nv2 = !sy;
    end else if (dom[4]) begin
      f2 = FACE_NY; mj2 = ay; mu2 = ax; nu2 = sx;  mv2 = az; nv2 = !sz;
    end else if (dom[5]) begin
      f2 = FACE_NZ; mj2 = az; mu2 = ax; nu2 = !sx; mv2 = ay; nv2 = !sy;
    end else begin
      // no strict winner: unit major, zero minors give uv at one half
      nd2 = 1'b1;
    end
  end

  // divider pipe: index 0 is the stage 2 register
  logic         dvl [0:D];
  face_t        dfc [0:D];
  logic         dnd [0:D];
  logic         dnu [0:D];
  logic         dnv [0:D];
  logic [C-1:0] dmj [0:D];
  logic [C-1:0] dru [0:D];
  logic [C-1:0] drv [0:D];
  logic [D-1:0] dqu [0:D];
  logic [D-1:0] dqv [0:D];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvl[0] <= 1'b0;
    end else if (adv) begin
      dvl[0] <= v1;
    end
    if (adv) begin
      dfc[0] <= f2;
      dnd[0] <= nd2;
      dnu[0] <= nu2;
      dnv[0] <= nv2;
      dmj[0] <= mj2;
      dru[0] <= mu2;
      drv[0] <= mv2;
      dqu[0] <= '0;
      dqv[0] <= '0;
    end
  end

  // restoring division of minor * 2^(UV_BITS-1) by major; minor < major always
  for (genvar k = 0; k < D; k++) begin : g_div
    logic [C:0] tu, tv;
    logic       bu, bv;
    assign tu = {dru[k], 1'b0};
    assign tv = {drv[k], 1'b0};
    assign bu = (tu >= {1'b0, dmj[k]});
    assign bv = (tv >= {1'b0, dmj[k]});
    always_ff @(posedge clk) begin
      if (rst) begin
        dvl[k+1] <= 1'b0;
      end else if (adv) begin
        dvl[k+1] <= dvl[k];
      end
      if (adv) begin
        dfc[k+1] <= dfc[k];
        dnd[k+1] <= dnd[k];
        dnu[k+1] <= dnu[k];
        dnv[k+1] <= dnv[k];
        dmj[k+1] <= dmj[k];
        dru[k+1] <= bu ? C'(tu - {1'b0, dmj[k]}) : tu[C-1:0];
        drv[k+1] <= bv ? C'(tv - {1'b0, dmj[k]}) : tv[C-1:0];
        dqu[k+1] <= {dqu[k][D-2:0], bu};
        dqv[k+1] <= {dqv[k][D-2:0], bv};
      end
    end
  end

  // stage u: face coords, atlas column offset folded in
  logic               vu;
  face_t              fu;
  logic               ndu, rowu;
  logic [1:0]         colu;
  logic [UV_BITS-1:0] uu, vvu;
  logic [UV_BITS:0]   xu;
  logic [UV_BITS-1:0] uc, vc;
  logic [1:0]         colc;
  logic [2:0]         radd;

  always_comb begin
    uc = dnu[D] ? HALF - {1'b0, dqu[D]} : HALF + {1'b0, dqu[D]};
    vc = dnv[D] ? HALF - {1'b0, dqv[D]} : HALF + {1'b0, dqv[D]};
    case (dfc[D])
      FACE_PX, FACE_NX: colc = 2'd0;
      FACE_PY, FACE_NY: colc = 2'd1;
      FACE_PZ, FACE_NZ: colc = 2'd2;
      default:          colc = 2'd0;
    endcase
    case (colc)
      2'd1:    radd = R1;
      2'd2:    radd = R2;
      default: radd = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vu <= 1'b0;
    end else if (adv) begin
      vu <= dvl[D];
    end
    if (adv) begin
      fu   <= dfc[D];
      ndu  <= dnd[D];
      rowu <= (dfc[D] == FACE_NX) || (dfc[D] == FACE_NY) || (dfc[D] == FACE_NZ);
      colu <= colc;
      uu   <= uc;
      vvu  <= vc;
      xu   <= {1'b0, uc} + (UV_BITS+1)'(radd);
    end
  end

  // stage m: divide by 3 through reciprocal multiply
  logic                 vm;
  face_t                fm;
  logic                 ndm, rowm;
  logic [1:0]           colm;
  logic [UV_BITS-1:0]   um, vvm;
  logic [UV_BITS+S:0]   prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vu;
    end
    if (adv) begin
      fm   <= fu;
      ndm  <= ndu;
      rowm <= rowu;
      colm <= colu;
      um   <= uu;
      vvm  <= vvu;
      prod <= xu * MULV;
    end
  end

  // output register
  logic [UV_BITS-1:0] koff;
  always_comb begin
    case (colm)
      2'd1:    koff = K1;
      2'd2:    koff = K2;
      default: koff = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_out.valid <= 1'b0;
    end else if (adv) begin
      uv_out.valid <= vm;
    end
    if (adv) begin
      uv_out.face             <= fm;
      uv_out.no_dominant_axis <= ndm;
      uv_out.face_u           <= um;
      uv_out.face_v           <= vvm;
      uv_out.atlas_u          <= koff + prod[S +: UV_BITS];
      uv_out.atlas_v          <= {rowm, vvm[UV_BITS-1:1]};
    end
  end

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !uv_out.valid |-> dir_in.ready)
    else $error("input stalled with empty output");
  a_default_result : assert property (@(posedge clk) disable iff (rst)
    uv_out.valid && uv_out.no_dominant_axis |->
      uv_out.face == FACE_PX && uv_out.face_u == HALF && uv_out.face_v == HALF)
    else $error("bad default result");
  a_face_range : assert property (@(posedge clk) disable iff (rst)
    uv_out.valid |-> uv_out.face <= FACE_NZ)
    else $error("face out of range");
  a_stall_freeze : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vm) && $stable(prod))
    else $error("pipe moved during stall");

endmodule

// File: tb/sv/cube_map_face_uv_checker.sv
`timescale 1ns / 1ps
module cube_map_face_uv_checker
  import cmfuv_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int UV_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  cmfuv_dir_if      dir_in,
  cmfuv_uv_if       uv_out,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    logic [2:0]         face;
    logic [UV_BITS-1:0] u;
    logic [UV_BITS-1:0] v;
    logic [UV_BITS-1:0] au;
    logic [UV_BITS-1:0] av;
    logic               none;
  } face_uv_t;

  localparam longint HALF  = 64'sd1 <<< (UV_BITS - 1);
  localparam longint UVMAX = (64'sd1 <<< UV_BITS) - 1;

  face_uv_t uv_queue[$];

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint coord(longint minor, longint major);
    longint q, r;
    if (major == 0) return HALF;
    q = mag(minor) * HALF / major;
    r = minor < 0 ? HALF - q : HALF + q;
    if (r < 0) r = 0;
    if (r > UVMAX) r = UVMAX;
    return r;
  endfunction

  function automatic bit wins(longint major, longint o1, longint o2);
    return major > 0 && mag(o1) < major && mag(o2) < major;
  endfunction

  function automatic face_uv_t project_dir(longint x, longint y, longint z);
    face_uv_t r;
    face_t f;
    longint u, v, au, av;
    f = FACE_PX; u = HALF; v = HALF; r.none = 1'b0;
    if (wins(x, y, z)) begin
      f = FACE_PX; u = coord(-z, x); v = coord(-y, x);
    end else if (wins(y, x, z)) begin
      f = FACE_PY; u = coord(x, y); v = coord(z, y);
    end else if (wins(z, x, y)) begin
      f = FACE_PZ; u = coord(x, z); v = coord(-y, z);
    end else if (wins(-x, y, z)) begin
      f = FACE_NX; u = coord(z, -x); v = coord(-y, -x);
    end else if (wins(-y, x, z)) begin
      f = FACE_NY; u = coord(x, -y); v = coord(-z, -y);
    end else if (wins(-z, x, y)) begin
      f = FACE_NZ; u = coord(-x, -z); v = coord(-y, -z);
    end else begin
      r.none = 1'b1;
    end
    au = (u + longint'(f % 3) * (UVMAX + 1)) / 3;
    av = (v + longint'(f / 3) * (UVMAX + 1)) / 2;
    if (au > UVMAX) au = UVMAX;
    if (av > UVMAX) av = UVMAX;
    r.face = f;
    r.u    = UV_BITS'(u);
    r.v    = UV_BITS'(v);
    r.au   = UV_BITS'(au);
    r.av   = UV_BITS'(av);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = uv_queue.size();

  initial errors = 0;

  always @(posedge clk) begin
    face_uv_t want;
    if (!rst) begin
      if (uv_out.valid && uv_out.ready) begin
        if (uv_queue.size() == 0) begin
          report_mismatch("unexpected item face", uv_out.face, -1);
        end else begin
          want = uv_queue.pop_front();
          if (uv_out.face !== want.face) report_mismatch("face", uv_out.face, want.face);
          if (uv_out.face_u !== want.u) report_mismatch("face_u", uv_out.face_u, want.u);
          if (uv_out.face_v !== want.v) report_mismatch("face_v", uv_out.face_v, want.v);
          if (uv_out.atlas_u !== want.au) report_mismatch("atlas_u", uv_out.atlas_u, want.au);
          if (uv_out.atlas_v !== want.av) report_mismatch("atlas_v", uv_out.atlas_v, want.av);
          if (uv_out.no_dominant_axis !== want.none)
            report_mismatch("no_dominant_axis", uv_out.no_dominant_axis, want.none);
        end
      end
      if (dir_in.valid && dir_in.ready)
        uv_queue.push_back(project_dir(dir_in.dir_x, dir_in.dir_y, dir_in.dir_z));
    end
  end

endmodule

// File: tb/sv/cube_map_face_uv_top_test.sv
`timescale 1ns / 1ps
module cube_map_face_uv_top_test;
  import cmfuv_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int UV_BITS    = 16;
  localparam int LATENCY    = UV_BITS + 5;
  // 20 directed and 550 random items, worst-case gaps and stalls on each side, then margin
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors;
  int   pending;

  cmfuv_dir_if #(.COORD_BITS(COORD_BITS)) dir_in ();
  cmfuv_uv_if  #(.UV_BITS(UV_BITS))       uv_out ();

  cube_map_face_uv_top #(.COORD_BITS(COORD_BITS), .UV_BITS(UV_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .dir_in (dir_in),
    .uv_out (uv_out)
  );

  cube_map_face_uv_checker #(.COORD_BITS(COORD_BITS), .UV_BITS(UV_BITS)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .dir_in  (dir_in),
    .uv_out  (uv_out),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one, with stretches of none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cube_map_face_uv_top_test failed");
      $finish;
    end
  end

  // sink side: random backpressure
  initial begin
    int g;
    uv_out.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        uv_out.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      uv_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // drive one item and hold it until it is taken
  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      dir_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    dir_in.valid <= 1'b1;
    dir_in.dir_x <= x;
    dir_in.dir_y <= y;
    dir_in.dir_z <= z;
    @(posedge clk);
    while (!dir_in.ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_comp();
    return 16'($urandom);
  endfunction

  initial begin
    logic signed [15:0] a, b, c, m;
    int k;
    dir_in.valid = 1'b0;
    dir_in.dir_x = '0;
    dir_in.dir_y = '0;
    dir_in.dir_z = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each face at full scale and extremes
    send_dir(16'sh7fff, 0, 0);
    send_dir(0, 16'sh7fff, 0);
    send_dir(0, 0, 16'sh7fff);
    send_dir(16'sh8000, 0, 0);
    send_dir(0, 16'sh8000, 0);
    send_dir(0, 0, 16'sh8000);
    // zero vector and ties: no dominant axis
    send_dir(0, 0, 0);
    send_dir(100, 100, 0);
    send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    send_dir(16'sh7fff, 16'sh8001, 5);
    // most negative minor vs smaller-magnitude major loses; minor near major
    send_dir(16'sh8000, 16'sh7fff, 16'sh8001);
    send_dir(16'sh7fff, 16'sh7ffe, 16'sh8001);
    send_dir(16'sh8001, 16'sh7fff, 16'sh7ffe);
    send_dir(1, 0, 0);
    send_dir(0, 0, -1);
    send_dir(3, -2, 2);
    send_dir(-5, 4, -4);
    send_dir(0, -7, 6);
    send_dir(16'shffff, 16'shffff, 16'shffff);
    send_dir(-3, 16'sh7fff, 16'sh8000);

    // random: mostly one clearly dominant axis with random minors
    for (int i = 0; i < 550; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        m = 16'($urandom_range(1, 32767));
        if ($urandom_range(0, 1)) m = -m;
        if ($urandom_range(0, 15) == 0) m = 16'sh8000;
        a = m;
        b = 16'($urandom_range(0, 65535));
        c = 16'($urandom_range(0, 65535));
        // shrink minors below the major most of the time
        if ($urandom_range(0, 3) != 0) begin
          b = 16'($signed(b) % (m == 16'sh8000 ? 32767 : (m < 0 ? -m : m)));
          c = 16'($signed(c) % (m == 16'sh8000 ? 32767 : (m < 0 ? -m : m)));
        end
        case ($urandom_range(0, 2))
          0: send_dir(a, b, c);
          1: send_dir(b, a, c);
          default: send_dir(b, c, a);
        endcase
      end else if (k < 8) begin
        // exact ties in magnitude
        a = rnd_comp();
        b = $urandom_range(0, 1) ? a : -a;
        c = rnd_comp();
        send_dir(a, c, b);
      end else begin
        send_dir(rnd_comp(), rnd_comp(), rnd_comp());
      end
    end
    dir_in.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("cube_map_face_uv_top_test passed");
    end else begin
      $display("cube_map_face_uv_top_test failed");
    end
    $finish;
  end

endmodule
